### hdl/i2da_pkg.sv
// Package with shared constants and controller/datapath interface types.
package i2da_pkg;

   localparam int VALUE_W      = 32;
   localparam int DIGITS       = 10;
   localparam int BCD_W        = 4 * DIGITS;
   localparam int STEPS        = VALUE_W;
   localparam int STEP_W       = $clog2(STEPS);
   localparam int CHAR_W       = 8;
   localparam int LIMIT_W      = 4;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CHAR_W-1:0]  CH_MINUS        = 8'd45;
   localparam logic [CHAR_W-1:0]  CH_ZERO         = 8'd48;
   localparam logic [LIMIT_W-1:0] MAX_TEXT        = 4'd11;
   localparam logic [LIMIT_W-1:0] MAX_CHARS_RESET = 4'd11;
   localparam logic [LIMIT_W-1:0] DIGITS_INIT     = 4'd10;

   localparam logic [CSR_ADDR_W-1:0] REG_MAX_CHARS = 3'd0;

   typedef struct packed {
      logic load;
      logic step;
      logic skip;
      logic emit_sign;
      logic emit_digit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic negative;
      logic top_zero;
      logic one_digit;
      logic slot_free;
      logic sign_last;
      logic digit_last;
   } dp_status_type;

endpackage

### hdl/i2da_csr.sv
// Configuration register block holding the character limit.
module i2da_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [i2da_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [i2da_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [i2da_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output logic [i2da_pkg::LIMIT_W-1:0]    max_chars
);
   import i2da_pkg::*;

   logic [LIMIT_W-1:0] max_chars_ff;
   logic [LIMIT_W-1:0] max_chars_in;
   logic               wr_en;
   logic               sel_max;

   assign sel_max    = (csr_paddr[CSR_ADDR_W-1:2] == REG_MAX_CHARS[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && sel_max;
   assign csr_pready = 1'b1;
   assign max_chars  = max_chars_ff;

   always_comb begin
      max_chars_in = max_chars_ff;
      if (wr_en) begin
         max_chars_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (sel_max) begin
         csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, max_chars_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
      end else begin
         max_chars_ff <= max_chars_in;
      end
   end

endmodule

### hdl/i2da_dp.sv
// Datapath: magnitude, shift-and-add-3 converter, digit counters and output register.
module i2da_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  i2da_pkg::ctrl_cmd_type        cmd,
   output i2da_pkg::dp_status_type       status,
   input  logic                          req_cmd,
   input  logic [i2da_pkg::VALUE_W-1:0]  req_value,
   input  logic [i2da_pkg::LIMIT_W-1:0]  max_chars,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [i2da_pkg::CHAR_W-1:0]   rsp_char_code,
   output logic                          rsp_last
);
   import i2da_pkg::*;

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [BCD_W-1:0]   bcd_fix;
   logic               neg_ff, neg_in;
   logic [LIMIT_W-1:0] ndig_ff, ndig_in;
   logic [LIMIT_W-1:0] left_ff, left_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic [LIMIT_W-1:0] limit;
   logic               negative;

   assign negative = req_cmd && req_value[VALUE_W-1];

   always_comb begin
      limit = max_chars;
      if (max_chars == '0) begin
         limit = {{(LIMIT_W-1){1'b0}}, 1'b1};
      end else if (max_chars > MAX_TEXT) begin
         limit = MAX_TEXT;
      end
   end

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_fix[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_fix[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   assign status.negative   = neg_ff;
   assign status.top_zero   = (bcd_ff[BCD_W-1 -: 4] == 4'd0);
   assign status.one_digit  = (ndig_ff == 4'd1);
   assign status.slot_free  = !valid_ff || rsp_ready;
   assign status.sign_last  = (left_ff == 4'd1);
   assign status.digit_last = (ndig_ff == 4'd1) || (left_ff == 4'd1);

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      ndig_in  = ndig_ff;
      left_in  = left_ff;
      valid_in = valid_ff && !rsp_ready;
      char_in  = char_ff;
      last_in  = last_ff;
      if (cmd.load) begin
         neg_in  = negative;
         bin_in  = negative ? (~req_value + {{(VALUE_W-1){1'b0}}, 1'b1}) : req_value;
         bcd_in  = '0;
         ndig_in = DIGITS_INIT;
         left_in = limit;
      end
      if (cmd.step) begin
         {bcd_in, bin_in} = {bcd_fix[BCD_W-2:0], bin_ff, 1'b0};
      end
      if (cmd.skip) begin
         bcd_in  = {bcd_ff[BCD_W-5:0], 4'd0};
         ndig_in = ndig_ff - 4'd1;
      end
      if (cmd.emit_sign) begin
         valid_in = 1'b1;
         char_in  = CH_MINUS;
         last_in  = status.sign_last;
         left_in  = left_ff - 4'd1;
      end
      if (cmd.emit_digit) begin
         valid_in = 1'b1;
         char_in  = CH_ZERO + {{(CHAR_W-4){1'b0}}, bcd_ff[BCD_W-1 -: 4]};
         last_in  = status.digit_last;
         bcd_in   = {bcd_ff[BCD_W-5:0], 4'd0};
         ndig_in  = ndig_ff - 4'd1;
         left_in  = left_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      ndig_ff <= ndig_in;
      left_ff <= left_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

endmodule

### hdl/i2da_ctrl.sv
// Controller state machine sequencing load, conversion, zero skipping and emission.
module i2da_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output i2da_pkg::ctrl_cmd_type  cmd,
   input  i2da_pkg::dp_status_type status
);
   import i2da_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_SKIP  = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_DIGIT = 3'd4;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (status.top_zero && !status.one_digit) begin
               cmd.skip = 1'b1;
            end else if (status.negative) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (status.slot_free) begin
               cmd.emit_sign = 1'b1;
               state_in = status.sign_last ? ST_IDLE : ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (status.slot_free) begin
               cmd.emit_digit = 1'b1;
               if (status.digit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### hdl/integer_to_decimal_ascii.sv
// Top level of the integer to decimal ASCII formatter.
//
//   channel   direction  ports                              meaning
//   req       in         req_cmd, req_value                 value and signed/unsigned mode
//   rsp       out        rsp_char_code, rsp_last            one ASCII character per item
//   csr       in/out     csr_psel .. csr_pready             max_chars at byte address 0
//
// An item is loaded, run through the shift-and-add-3 converter and stripped of its leading
// zero digits (up to nine); then the first character is chosen and the characters are
// emitted in order. A new item is taken in the idle state, while the final character may
// still wait in the output register. A stalled output holds emission in place. Reset is
// synchronous and returns max_chars to 11.
module integer_to_decimal_ascii (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [i2da_pkg::VALUE_W-1:0]    req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [i2da_pkg::CHAR_W-1:0]     rsp_char_code,
   output logic                            rsp_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [i2da_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [i2da_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [i2da_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import i2da_pkg::*;

   ctrl_cmd_type       cmd;
   dp_status_type      status;
   logic [LIMIT_W-1:0] max_chars;

   i2da_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_chars   (max_chars)
   );

   i2da_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   i2da_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_cmd       (req_cmd),
      .req_value     (req_value),
      .max_chars     (max_chars),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

### hdl/i2da_checker.sv
// Port-level checker for the formatter and its bind to the top level.
module i2da_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [i2da_pkg::CHAR_W-1:0]     rsp_char_code,
   input logic                            rsp_last
);
   import i2da_pkg::*;

   // An output item that is not taken stays offered unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_code) && $stable(rsp_last))
      else $error("result item changed while stalled");

   // Every character is a minus sign or a decimal digit.
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_code == CH_MINUS) ||
                    (rsp_char_code >= CH_ZERO && rsp_char_code <= CH_ZERO + 8'd9))
      else $error("result character is not a sign or digit");

   // The block is busy converting right after it takes an item.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again right after an item");

   // Reset leaves no result on offer.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind integer_to_decimal_ascii i2da_checker u_i2da_checker (.*);

### test/integer_to_decimal_ascii_test.sv
// Testbench for integer_to_decimal_ascii: directed table, random values and limit sweeps.
module integer_to_decimal_ascii_test;
   timeunit 1ns;
   timeprecision 1ps;

   import i2da_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } char_item_type;

   typedef struct {
      logic                cmd;
      logic [VALUE_W-1:0]  value;
      logic [LIMIT_W-1:0]  limit;
      string               text;
   } text_case_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_cmd;
   logic [VALUE_W-1:0]    req_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [CHAR_W-1:0]     rsp_char_code;
   logic                  rsp_last;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   char_item_type         expected_chars[$];
   logic [LIMIT_W-1:0]    active_limit;
   int                    error_count = 0;
   int                    burst_left = 0;
   bit                    hold_request = 0;
   bit                    hold_done = 0;
   int                    hold_left = 0;
   int                    pattern_left = 0;
   int                    stall_style = 0;
   int                    stall_phase = 0;

   text_case_type directed_rows [22] = '{
      '{1'b0, 32'h0000_0000, 4'd11, "0"},
      '{1'b1, 32'h0000_0000, 4'd11, "0"},
      '{1'b0, 32'hFFFF_FFFF, 4'd11, "4294967295"},
      '{1'b1, 32'hFFFF_FFFF, 4'd11, "-1"},
      '{1'b1, 32'h8000_0000, 4'd11, "-2147483648"},
      '{1'b0, 32'h8000_0000, 4'd11, "2147483648"},
      '{1'b1, 32'h7FFF_FFFF, 4'd11, "2147483647"},
      '{1'b0, 32'h3B9A_CA00, 4'd11, "1000000000"},
      '{1'b0, 32'h3B9A_C9FF, 4'd11, "999999999"},
      '{1'b0, 32'd9,         4'd11, "9"},
      '{1'b0, 32'd10,        4'd11, "10"},
      '{1'b1, 32'd12345,     4'd11, ""},
      '{1'b1, 32'h8000_0000, 4'd0,  "-"},
      '{1'b0, 32'd12345,     4'd0,  "1"},
      '{1'b1, 32'hFFFF_FFF6, 4'd1,  "-"},
      '{1'b0, 32'd987,       4'd1,  "9"},
      '{1'b0, 32'd0,         4'd1,  "0"},
      '{1'b1, -32'd12345,    4'd4,  "-123"},
      '{1'b0, 32'hFFFF_FFFF, 4'd4,  "4294"},
      '{1'b1, 32'h8000_0000, 4'd15, "-2147483648"},
      '{1'b1, 32'h8000_0001, 4'd12, "-2147483647"},
      '{1'b1, 32'h8000_0000, 4'd10, "-214748364"}
   };

   integer_to_decimal_ascii dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("integer_to_decimal_ascii_test: FAIL");
      $finish;
   end

   function automatic void format_decimal(input logic sign_mode, input logic [VALUE_W-1:0] raw,
                                          input logic [LIMIT_W-1:0] limit_reg);
      int                 room;
      int                 count;
      logic               negative;
      logic [VALUE_W-1:0] magnitude;
      logic [3:0]         digits[$];
      char_item_type      text[$];
      room = (limit_reg == 0) ? 1 : (limit_reg > MAX_TEXT) ? int'(MAX_TEXT) : int'(limit_reg);
      negative = sign_mode && raw[VALUE_W-1];
      magnitude = negative ? -raw : raw;
      count = 0;
      do begin
         digits.push_front(4'(magnitude % 10));
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (negative) begin
         text.push_back('{CH_MINUS, 1'b0});
         count = 1;
      end
      foreach (digits[i]) begin
         if (count < room) begin
            text.push_back('{CH_ZERO + CHAR_W'(digits[i]), 1'b0});
            count++;
         end
      end
      text[text.size()-1].last = 1'b1;
      foreach (text[i]) expected_chars.push_back(text[i]);
   endfunction

   function automatic logic [VALUE_W-1:0] random_value();
      int          k;
      logic [63:0] ten_pow;
      logic [63:0] wide;
      k = $urandom_range(1, 10);
      ten_pow = 1;
      repeat (k) ten_pow = ten_pow * 10;
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return VALUE_W'(wide % ten_pow);
         2: return VALUE_W'(ten_pow - 1 + $urandom_range(0, 2));
         3: return VALUE_W'($urandom_range(0, 20));
         4: return 32'h7FFF_FFF8 + VALUE_W'($urandom_range(0, 15));
         default: return -VALUE_W'(wide % ten_pow);
      endcase
   endfunction

   task automatic send_item(input logic cmd, input logic [VALUE_W-1:0] value, input string text);
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_value <= value;
      do @(posedge clock); while (!(req_valid && req_ready));
      burst_left--;
      if (text.len() == 0) begin
         format_decimal(cmd, value, active_limit);
      end else begin
         for (int i = 0; i < text.len(); i++) begin
            expected_chars.push_back('{CHAR_W'(text[i]), i == text.len() - 1});
         end
      end
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] limit);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= REG_MAX_CHARS;
      csr_pwdata <= CSR_DATA_W'(limit);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[LIMIT_W-1:0] !== limit) begin
         $display("%0t: max_chars read back expected %0d, actual %0d", $time, limit,
                  csr_prdata[LIMIT_W-1:0]);
         error_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      active_limit = limit;
   endtask

   always @(negedge clock) begin
      if (hold_request && !hold_done) begin
         hold_left = 400;
         hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            stall_style = $urandom_range(0, 2);
            pattern_left = $urandom_range(50, 300);
         end
         pattern_left--;
         stall_phase++;
         case (stall_style)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= (stall_phase % 7) >= 3;
         endcase
      end
   end

   always @(posedge clock) begin : check_output
      char_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: character with none expected, actual %h last %b", $time,
                     rsp_char_code, rsp_last);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_char_code !== want.code) begin
               $display("%0t: char_code expected %h, actual %h", $time, want.code, rsp_char_code);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %b, actual %b", $time, want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [LIMIT_W-1:0] segment_limits [7];
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = 1'b0;
      req_value = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      active_limit = MAX_CHARS_RESET;
      segment_limits = '{4'd11, 4'd3, 4'd0, 4'd15, 4'd1, 4'd7, 4'($urandom_range(0, 15))};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].limit != active_limit) write_limit(directed_rows[i].limit);
         send_item(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].text);
      end

      foreach (segment_limits[s]) begin
         write_limit(segment_limits[s]);
         for (int n = 0; n < 44; n++) begin
            if (s == 0 && n == 15) hold_request = 1;
            send_item(1'($urandom_range(0, 1)), random_value(), "");
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("integer_to_decimal_ascii_test: PASS");
      end else begin
         $display("integer_to_decimal_ascii_test: FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/i2da_pkg.sv
hdl/i2da_csr.sv
hdl/i2da_dp.sv
hdl/i2da_ctrl.sv
hdl/integer_to_decimal_ascii.sv
hdl/i2da_checker.sv
test/integer_to_decimal_ascii_test.sv
